[rtl/lruwbd_pkg.sv]
// ----------------------------------------------------------------------------
// lruwbd_pkg
// shared field widths, operation and status codes for the buffer directory
// ----------------------------------------------------------------------------
package lruwbd_pkg;

    // field widths
    localparam int unsigned OP_W       = 2;
    localparam int unsigned TAG_W      = 32;
    localparam int unsigned LEN_W      = 17;
    localparam int unsigned FILL_W     = 17;
    localparam int unsigned STAT_W     = 2;
    localparam int unsigned IDX_OUT_W  = 4;
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 56;

    // block size register reset value
    localparam logic [FILL_W-1:0] BLOCK_BYTES_RST = 17'd4096;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_WB   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd3;

endpackage

[rtl/lru_write_buffer_directory.sv]
// ----------------------------------------------------------------------------
// lru_write_buffer_directory
// result path: allocate, successful append and read run both sweeps;
//   miss, full and unused codes skip the touch sweep
// throughput: one request at a time, next request taken in the cycle after
//   the result is loaded; both sweeps go through the single age memory read port
// reset: aresetn synchronous active low, all entries free, ages read as zero,
//   block size back to 4096
// ----------------------------------------------------------------------------
// Directory for a fully associative write buffer with counter based LRU.
// Each entry holds a tag, a valid mark, an age and a fill count.
// A request is processed in four phases:
//   scan  : one entry per cycle through the shared compare unit, finding the
//           first oldest entry (allocate) or the first valid tag match
//   eval  : status, fill sum and block limit check, tag and fill writes
//   touch : second sweep rewriting every age against the reference age
//   done  : result waits for a free output register
// ----------------------------------------------------------------------------
module lru_write_buffer_directory #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration: block_bytes
    input  logic                               cfg_wr_en,
    input  logic [lruwbd_pkg::FILL_W-1:0]      cfg_wr_data,
    // request channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [1:0] operation, [33:2] tag, [50:34] length, [55:51] zero
    input  logic [lruwbd_pkg::IN_DATA_W-1:0]   s_tdata,
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [1:0] status, [5:2] entry_index, [22:6] fill_bytes, [54:23] evicted_tag,
    // [55] zero
    output logic [lruwbd_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    localparam int unsigned TAG_W  = lruwbd_pkg::TAG_W;
    localparam int unsigned FILL_W = lruwbd_pkg::FILL_W;
    localparam int unsigned OP_W   = lruwbd_pkg::OP_W;
    localparam int unsigned STAT_W = lruwbd_pkg::STAT_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_TOUCH = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // entry storage: tag, fill and age memories, valid marks in flops
    logic [TAG_W-1:0]  tag_mem  [ENTRIES];
    logic [FILL_W-1:0] fill_mem [ENTRIES];
    logic [IW-1:0]     age_mem  [ENTRIES];

    logic [TAG_W-1:0]  tag_rd_reg;
    logic [FILL_W-1:0] fill_rd_reg;
    logic [IW-1:0]     age_rd_reg;

    // control state
    logic [2:0]          state_reg, state_next;
    logic [IW-1:0]       cnt_reg, cnt_next;
    logic                iss_done_reg, iss_done_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [IW-1:0]       rd_idx_reg, rd_idx_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    // an age never written reads as zero
    logic [ENTRIES-1:0]  age_vld_reg, age_vld_next;
    logic [FILL_W-1:0]   block_bytes_reg, block_bytes_next;
    logic                hit_reg, hit_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // latched request
    logic [OP_W-1:0]     op_reg, op_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [FILL_W-1:0]   len_reg, len_next;

    // selected entry captured during the scan
    logic [IW-1:0]       sel_idx_reg, sel_idx_next;
    logic [IW-1:0]       sel_age_reg, sel_age_next;
    logic [TAG_W-1:0]    sel_tag_reg, sel_tag_next;
    logic [FILL_W-1:0]   sel_fill_reg, sel_fill_next;
    logic                sel_valid_reg, sel_valid_next;

    // result fields
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic [IW-1:0]       res_idx_reg, res_idx_next;
    logic [FILL_W-1:0]   res_fill_reg, res_fill_next;
    logic [TAG_W-1:0]    res_evict_reg, res_evict_next;
    logic [lruwbd_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // memory ports
    logic                tag_we, fill_we, age_we;
    logic [FILL_W-1:0]   fill_wd;
    logic [IW-1:0]       age_wd;

    // shared unit signals
    logic [IW-1:0]       age_eff;
    logic [FILL_W-1:0]   fill_eff;
    logic                ent_valid;
    logic [FILL_W:0]     fill_sum;
    logic [IW-1:0]       age_inc;
    logic                out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // memories: one read at cnt, one write per cycle
    always_ff @(posedge aclk) begin
        tag_rd_reg  <= tag_mem[cnt_reg];
        fill_rd_reg <= fill_mem[cnt_reg];
        age_rd_reg  <= age_mem[cnt_reg];
        if (tag_we) begin
            tag_mem[sel_idx_reg] <= tag_reg;
        end
        if (fill_we) begin
            fill_mem[sel_idx_reg] <= fill_wd;
        end
        if (age_we) begin
            age_mem[rd_idx_reg] <= age_wd;
        end
    end

    // entry read back with the reset value for never written entries
    assign ent_valid = valid_reg[rd_idx_reg];
    assign age_eff   = age_vld_reg[rd_idx_reg] ? age_rd_reg : '0;
    assign fill_eff  = ent_valid ? fill_rd_reg : '0;
    assign age_inc   = (age_eff == LAST_IDX) ? '0 : age_eff + 1'b1;
    assign fill_sum  = {1'b0, sel_fill_reg} + {1'b0, len_reg};

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        iss_done_next    = iss_done_reg;
        rd_vld_next      = 1'b0;
        rd_idx_next      = cnt_reg;
        valid_next       = valid_reg;
        age_vld_next     = age_vld_reg;
        block_bytes_next = block_bytes_reg;
        hit_next         = hit_reg;
        op_next          = op_reg;
        tag_next         = tag_reg;
        len_next         = len_reg;
        sel_idx_next     = sel_idx_reg;
        sel_age_next     = sel_age_reg;
        sel_tag_next     = sel_tag_reg;
        sel_fill_next    = sel_fill_reg;
        sel_valid_next   = sel_valid_reg;
        res_status_next  = res_status_reg;
        res_idx_next     = res_idx_reg;
        res_fill_next    = res_fill_reg;
        res_evict_next   = res_evict_reg;
        m_tdata_next     = m_tdata_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        tag_we           = 1'b0;
        fill_we          = 1'b0;
        fill_wd          = '0;
        age_we           = 1'b0;
        age_wd           = '0;

        if (cfg_wr_en) begin
            block_bytes_next = cfg_wr_data;
        end

        // address sweep shared by scan and touch
        if ((state_reg == S_SCAN || state_reg == S_TOUCH) && !iss_done_reg) begin
            rd_vld_next = 1'b1;
            if (cnt_reg == LAST_IDX) begin
                iss_done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next       = s_tdata[1:0];
                    tag_next      = s_tdata[33:2];
                    len_next      = s_tdata[50:34];
                    cnt_next      = '0;
                    iss_done_next = 1'b0;
                    hit_next      = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (rd_vld_reg) begin
                    if (op_reg == lruwbd_pkg::OP_ALLOC) begin
                        // first entry with the greatest age
                        if (rd_idx_reg == '0 || age_eff > sel_age_reg) begin
                            sel_idx_next   = rd_idx_reg;
                            sel_age_next   = age_eff;
                            sel_tag_next   = tag_rd_reg;
                            sel_fill_next  = fill_eff;
                            sel_valid_next = ent_valid;
                        end
                    end else if (!hit_reg && ent_valid && tag_rd_reg == tag_reg) begin
                        // lowest numbered valid match
                        hit_next      = 1'b1;
                        sel_idx_next  = rd_idx_reg;
                        sel_age_next  = age_eff;
                        sel_fill_next = fill_eff;
                    end
                    if (rd_idx_reg == LAST_IDX) begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                cnt_next        = '0;
                iss_done_next   = 1'b0;
                res_status_next = lruwbd_pkg::STAT_MISS;
                res_idx_next    = '0;
                res_fill_next   = '0;
                res_evict_next  = '0;
                state_next      = S_DONE;
                unique case (op_reg)
                    lruwbd_pkg::OP_ALLOC: begin
                        res_status_next = sel_valid_reg ? lruwbd_pkg::STAT_WB
                                                        : lruwbd_pkg::STAT_OK;
                        res_idx_next    = sel_idx_reg;
                        res_fill_next   = sel_fill_reg;
                        res_evict_next  = sel_valid_reg ? sel_tag_reg : '0;
                        // install new tag with an empty block
                        tag_we          = 1'b1;
                        fill_we         = 1'b1;
                        fill_wd         = '0;
                        valid_next[sel_idx_reg] = 1'b1;
                        state_next      = S_TOUCH;
                    end
                    lruwbd_pkg::OP_APPEND: begin
                        if (hit_reg) begin
                            res_idx_next = sel_idx_reg;
                            if (fill_sum >= {1'b0, block_bytes_reg}) begin
                                // block would reach capacity, nothing changes
                                res_status_next = lruwbd_pkg::STAT_FULL;
                                res_fill_next   = sel_fill_reg;
                            end else begin
                                res_status_next = lruwbd_pkg::STAT_OK;
                                res_fill_next   = fill_sum[FILL_W-1:0];
                                fill_we         = 1'b1;
                                fill_wd         = fill_sum[FILL_W-1:0];
                                state_next      = S_TOUCH;
                            end
                        end
                    end
                    lruwbd_pkg::OP_READ: begin
                        if (hit_reg) begin
                            res_status_next = lruwbd_pkg::STAT_OK;
                            res_idx_next    = sel_idx_reg;
                            res_fill_next   = sel_fill_reg;
                            state_next      = S_TOUCH;
                        end
                    end
                    default: begin
                        // unused code reports a miss
                    end
                endcase
            end
            S_TOUCH: begin
                if (rd_vld_reg) begin
                    age_we = 1'b1;
                    age_vld_next[rd_idx_reg] = 1'b1;
                    if (rd_idx_reg == sel_idx_reg) begin
                        age_wd = '0;
                    end else if (age_eff <= sel_age_reg) begin
                        age_wd = age_inc;
                    end else begin
                        age_wd = age_eff;
                    end
                    if (rd_idx_reg == LAST_IDX) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, res_evict_reg, res_fill_reg,
                                     lruwbd_pkg::IDX_OUT_W'(res_idx_reg),
                                     res_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            iss_done_reg    <= 1'b0;
            rd_vld_reg      <= 1'b0;
            valid_reg       <= '0;
            age_vld_reg     <= '0;
            block_bytes_reg <= lruwbd_pkg::BLOCK_BYTES_RST;
            hit_reg         <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            iss_done_reg    <= iss_done_next;
            rd_vld_reg      <= rd_vld_next;
            valid_reg       <= valid_next;
            age_vld_reg     <= age_vld_next;
            block_bytes_reg <= block_bytes_next;
            hit_reg         <= hit_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        op_reg         <= op_next;
        tag_reg        <= tag_next;
        len_reg        <= len_next;
        sel_idx_reg    <= sel_idx_next;
        sel_age_reg    <= sel_age_next;
        sel_tag_reg    <= sel_tag_next;
        sel_fill_reg   <= sel_fill_next;
        sel_valid_reg  <= sel_valid_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_fill_reg   <= res_fill_next;
        res_evict_reg  <= res_evict_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule

[test/lru_write_buffer_directory_tb.sv]
// ----------------------------------------------------------------------------
// lru_write_buffer_directory_tb
// self-checking bench for the lru write-buffer directory
// ----------------------------------------------------------------------------
// A shadow copy of the directory (tags, valid marks, ages, fills and the
// block size) predicts the reply to every accepted request. A short walk
// through hand-written requests covers the reset state, the field
// extremes, the full and miss cases, duplicate tags and the unused
// operation code. Seven random phases follow, each with its own block size
// and its own level of sender gaps and receiver stalls. The last phase
// runs with no idling at all.
// ----------------------------------------------------------------------------
module lru_write_buffer_directory_tb;

    // widths and codes shared with the block
    localparam int unsigned OP_W       = lruwbd_pkg::OP_W;
    localparam int unsigned TAG_W      = lruwbd_pkg::TAG_W;
    localparam int unsigned LEN_W      = lruwbd_pkg::LEN_W;
    localparam int unsigned FILL_W     = lruwbd_pkg::FILL_W;
    localparam int unsigned STAT_W     = lruwbd_pkg::STAT_W;
    localparam int unsigned IDX_OUT_W  = lruwbd_pkg::IDX_OUT_W;
    localparam int unsigned IN_DATA_W  = lruwbd_pkg::IN_DATA_W;
    localparam int unsigned OUT_DATA_W = lruwbd_pkg::OUT_DATA_W;

    localparam logic [FILL_W-1:0] BLOCK_BYTES_RST = lruwbd_pkg::BLOCK_BYTES_RST;

    localparam logic [OP_W-1:0] OP_ALLOC  = lruwbd_pkg::OP_ALLOC;
    localparam logic [OP_W-1:0] OP_APPEND = lruwbd_pkg::OP_APPEND;
    localparam logic [OP_W-1:0] OP_READ   = lruwbd_pkg::OP_READ;

    localparam logic [STAT_W-1:0] STAT_OK   = lruwbd_pkg::STAT_OK;
    localparam logic [STAT_W-1:0] STAT_WB   = lruwbd_pkg::STAT_WB;
    localparam logic [STAT_W-1:0] STAT_MISS = lruwbd_pkg::STAT_MISS;
    localparam logic [STAT_W-1:0] STAT_FULL = lruwbd_pkg::STAT_FULL;

    localparam int ENTRIES       = 16;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 200;
    localparam int TAIL_CYCLES   = 2*ENTRIES + 8;
    localparam int DRAIN_CYCLES  = 4000;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int MAX_REPORTS   = 10;

    // code that the directory ignores, answered with a bare miss
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // reply fields, status in the lowest bits to match m_tdata
    typedef struct packed {
        logic [TAG_W-1:0]     evicted;
        logic [FILL_W-1:0]    fill;
        logic [IDX_OUT_W-1:0] entry;
        logic [STAT_W-1:0]    status;
    } dir_reply_t;

    // one line of the directed walk
    typedef struct {
        logic [OP_W-1:0]  op;
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
        bit               typed;
        dir_reply_t       reply;
    } dir_row_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // block ports
    logic                  cfg_wr_en   = 1'b0;
    logic [FILL_W-1:0]     cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    lru_write_buffer_directory #(
        .ENTRIES (ENTRIES)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // shadow directory, kept in step with every accepted request
    logic [TAG_W-1:0]  shadow_tag   [ENTRIES];
    logic              shadow_valid [ENTRIES];
    logic [3:0]        shadow_age   [ENTRIES];
    logic [FILL_W-1:0] shadow_fill  [ENTRIES];
    logic [FILL_W-1:0] shadow_block;

    // replies owed by the block, oldest first
    dir_reply_t pending_replies[$];
    dir_row_t   directed_rows[$];

    // bookkeeping
    int fault_count   = 0;
    int directed_sent = 0;
    int random_sent   = 0;
    int sizes_used    = 1;
    int replies_by_status [4] = '{0, 0, 0, 0};

    // idling levels, percent per cycle, changed per phase
    int send_gap_pct = 0;
    int stall_pct    = 0;

    // ------------------------------------------------------------------------
    // shadow directory behaviour
    // ------------------------------------------------------------------------

    // lowest-numbered valid entry holding the tag, -1 when absent
    function automatic int find_tag(input logic [TAG_W-1:0] t);
        for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_valid[i] && shadow_tag[i] == t)
                return i;
        end
        return -1;
    endfunction

    // ages at or below the pivot move up one, the touched entry goes to zero
    function automatic void touch_entry(input int e);
        logic [3:0] pivot;
        pivot = shadow_age[e];
        for (int i = 0; i < ENTRIES; i++) begin
            // 4-bit wrap is the modulo over sixteen entries
            if (i != e && shadow_age[i] <= pivot)
                shadow_age[i] = shadow_age[i] + 4'd1;
        end
        shadow_age[e] = '0;
    endfunction

    // reply to one request, updating the shadow as the block would
    function automatic dir_reply_t shadow_access(input logic [OP_W-1:0]  op,
                                                 input logic [TAG_W-1:0] tag,
                                                 input logic [LEN_W-1:0] len);
        dir_reply_t r;
        int         victim;
        int         hit;
        logic [3:0] oldest;
        logic [17:0] sum;
        r        = '0;
        r.status = STAT_MISS;
        if (op == OP_ALLOC) begin
            // first entry holding the greatest age is the victim
            victim = 0;
            oldest = shadow_age[0];
            for (int i = 1; i < ENTRIES; i++) begin
                if (shadow_age[i] > oldest) begin
                    oldest = shadow_age[i];
                    victim = i;
                end
            end
            r.fill = shadow_fill[victim];
            if (shadow_valid[victim]) begin
                r.status  = STAT_WB;
                r.evicted = shadow_tag[victim];
            end else begin
                r.status = STAT_OK;
            end
            shadow_tag[victim]   = tag;
            shadow_valid[victim] = 1'b1;
            shadow_fill[victim]  = '0;
            touch_entry(victim);
            r.entry = IDX_OUT_W'(victim);
        end else if (op == OP_APPEND || op == OP_READ) begin
            hit = find_tag(tag);
            if (hit >= 0) begin
                r.entry = IDX_OUT_W'(hit);
                if (op == OP_APPEND) begin
                    sum = {1'b0, shadow_fill[hit]} + {1'b0, len};
                    if (sum >= {1'b0, shadow_block}) begin
                        // reaching the block size leaves everything alone
                        r.status = STAT_FULL;
                        r.fill   = shadow_fill[hit];
                    end else begin
                        shadow_fill[hit] = sum[FILL_W-1:0];
                        touch_entry(hit);
                        r.status = STAT_OK;
                        r.fill   = shadow_fill[hit];
                    end
                end else begin
                    r.status = STAT_OK;
                    r.fill   = shadow_fill[hit];
                    touch_entry(hit);
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // directed rows
    // ------------------------------------------------------------------------

    function automatic dir_row_t make_row(input logic [OP_W-1:0]      op,
                                          input logic [TAG_W-1:0]     tag,
                                          input logic [LEN_W-1:0]     len,
                                          input bit                   typed,
                                          input logic [STAT_W-1:0]    status,
                                          input logic [IDX_OUT_W-1:0] entry,
                                          input logic [FILL_W-1:0]    fill,
                                          input logic [TAG_W-1:0]     evicted);
        dir_row_t row;
        row.op            = op;
        row.tag           = tag;
        row.len           = len;
        row.typed         = typed;
        row.reply.status  = status;
        row.reply.entry   = entry;
        row.reply.fill    = fill;
        row.reply.evicted = evicted;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // present one request and hold it until taken, then log its reply
    task automatic offer(input logic [OP_W-1:0]  op,
                         input logic [TAG_W-1:0] tag,
                         input logic [LEN_W-1:0] len,
                         input bit               typed,
                         input dir_reply_t       typed_reply);
        dir_reply_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, len, tag, op};
        do @(posedge aclk); while (!s_tready);
        predicted = shadow_access(op, tag, len);
        pending_replies.push_back(typed ? typed_reply : predicted);
    endtask

    // sender idles for a burst
    task automatic pause_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // sender holds off until every owed reply has come back
    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_replies.size() != 0);
    endtask

    // new block size, only with the directory idle
    task automatic write_block_size(input logic [FILL_W-1:0] bytes);
        wait_for_replies();
        repeat (3) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= bytes;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        shadow_block  = bytes;
        sizes_used++;
    endtask

    // random request, mostly aimed at tags that are present
    task automatic pick_request(output logic [OP_W-1:0]  op,
                                output logic [TAG_W-1:0] tag,
                                output logic [LEN_W-1:0] len);
        int live[$];
        int roll;
        int room;
        for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_valid[i])
                live.push_back(i);
        end
        roll = $urandom_range(0, 99);
        op   = OP_UNUSED;
        tag  = $urandom();
        len  = LEN_W'($urandom());
        if (roll < 15 || live.size() == 0) begin
            op = OP_ALLOC;
            case ($urandom_range(0, 2))
                0: tag = $urandom();
                1: tag = $urandom_range(0, 15);
                default: begin
                    // duplicate of a tag already held
                    if (live.size() != 0)
                        tag = shadow_tag[live[$urandom_range(0, live.size() - 1)]];
                end
            endcase
        end else if (roll < 82) begin
            op   = (roll < 60) ? OP_APPEND : OP_READ;
            tag  = shadow_tag[live[$urandom_range(0, live.size() - 1)]];
            room = int'(shadow_block) - int'(shadow_fill[find_tag(tag)]);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = LEN_W'($urandom_range(0, shadow_block / 16 + 2));
                6: len = LEN_W'(room - 1);  // last byte that still fits
                7: len = LEN_W'(room);      // exactly reaches the block size
                8: ;                        // any length at all
                default: len = $urandom_range(0, 1) ? '1 : '0;
            endcase
        end else if (roll < 95) begin
            // lookup of a tag that is most likely absent
            op = $urandom_range(0, 1) ? OP_APPEND : OP_READ;
        end
    endtask

    // ------------------------------------------------------------------------
    // reply side
    // ------------------------------------------------------------------------

    // receiver stalls in bursts, level set per phase
    initial begin : reply_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold = hold - 1;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                m_tready <= 1'b0;
                hold = $urandom_range(1, 18) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic log_fault(input string what, input dir_reply_t got, input dir_reply_t want);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display({"reply mismatch (%s): got status %0d entry %0d fill %0d evicted %h,",
                      " wanted status %0d entry %0d fill %0d evicted %h"},
                     what, got.status, got.entry, got.fill, got.evicted,
                     want.status, want.entry, want.fill, want.evicted);
    endtask

    // compare every accepted reply with the oldest one owed
    always @(posedge aclk) begin : reply_check
        dir_reply_t got;
        dir_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = dir_reply_t'(m_tdata[OUT_DATA_W-2:0]);
            replies_by_status[got.status]++;
            if (pending_replies.size() == 0) begin
                log_fault("no request outstanding", got, '0);
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status || got.entry !== want.entry ||
                    got.fill !== want.fill || got.evicted !== want.evicted)
                    log_fault("field", got, want);
            end
        end
    end

    // ------------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------------

    initial begin : run
        logic [OP_W-1:0]   op;
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
        logic [FILL_W-1:0] bytes;
        dir_row_t          row;

        // directed walk, block size still at its reset value of 4096
        directed_rows.push_back(make_row(OP_READ,   32'h0000_0000, 17'h0,     1, STAT_MISS, 0, 0, 0));
        directed_rows.push_back(make_row(OP_APPEND, 32'h0000_0000, 17'h1,     1, STAT_MISS, 0, 0, 0));
        directed_rows.push_back(make_row(OP_UNUSED, 32'hFFFF_FFFF, 17'h1FFFF, 1, STAT_MISS, 0, 0, 0));
        directed_rows.push_back(make_row(OP_ALLOC,  32'hFFFF_FFFF, 17'h0,     1, STAT_OK,   0, 0, 0));
        directed_rows.push_back(make_row(OP_APPEND, 32'hFFFF_FFFF, 17'h0,     1, STAT_OK,   0, 0, 0));
        directed_rows.push_back(make_row(OP_APPEND, 32'hFFFF_FFFF, 17'd4095,  1, STAT_OK,   0, 4095, 0));
        directed_rows.push_back(make_row(OP_APPEND, 32'hFFFF_FFFF, 17'd1,     1, STAT_FULL, 0, 4095, 0));
        directed_rows.push_back(make_row(OP_APPEND, 32'hFFFF_FFFF, 17'h1FFFF, 1, STAT_FULL, 0, 4095, 0));
        directed_rows.push_back(make_row(OP_READ,   32'hFFFF_FFFF, 17'h0,     1, STAT_OK,   0, 4095, 0));
        // duplicates: allocate never checks for a present tag
        directed_rows.push_back(make_row(OP_ALLOC,  32'h0000_0000, 17'h0,     0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(OP_ALLOC,  32'h0000_0000, 17'h1FFFF, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(OP_APPEND, 32'h0000_0000, 17'h10000, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(OP_APPEND, 32'h0000_0000, 17'd7,     0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(OP_READ,   32'h0000_0000, 17'h0,     0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(OP_ALLOC,  32'h8000_0000, 17'h0,     0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(OP_ALLOC,  32'h0000_0001, 17'h0,     0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(OP_READ,   32'h1234_5678, 17'h0,     1, STAT_MISS, 0, 0, 0));
        directed_rows.push_back(make_row(OP_APPEND, 32'h7FFF_FFFF, 17'h0FFFF, 1, STAT_MISS, 0, 0, 0));
        directed_rows.push_back(make_row(OP_UNUSED, 32'h0000_0000, 17'h0,     1, STAT_MISS, 0, 0, 0));
        directed_rows.push_back(make_row(OP_READ,   32'hFFFF_FFFF, 17'h0,     0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(OP_ALLOC,  32'hA5A5_5A5A, 17'h0,     0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(OP_APPEND, 32'hA5A5_5A5A, 17'h00AAA, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(OP_APPEND, 32'hA5A5_5A5A, 17'h00555, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(OP_READ,   32'hA5A5_5A5A, 17'h0,     0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(OP_APPEND, 32'h8000_0000, 17'h0,     0, 0, 0, 0, 0));

        // shadow starts as the block does after reset
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_tag[i]   = '0;
            shadow_valid[i] = 1'b0;
            shadow_age[i]   = '0;
            shadow_fill[i]  = '0;
        end
        shadow_block = BLOCK_BYTES_RST;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            offer(row.op, row.tag, row.len, row.typed, row.reply);
            directed_sent++;
        end

        // random phases, each with its own block size and idling level
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: bytes = 17'd65536;
                1: bytes = 17'd1;
                2: bytes = FILL_W'($urandom_range(2, 65535));
                3: bytes = 17'd0;      // every append reports full
                4: bytes = BLOCK_BYTES_RST;
                5: bytes = FILL_W'($urandom_range(16, 512));
                default: bytes = FILL_W'($urandom_range(2, 65535));
            endcase
            write_block_size(bytes);

            // quiet, gappy sender or heavy both ways; the last phase runs flat out
            case (ph % 3)
                0: begin send_gap_pct = 0;  stall_pct = 20; end
                1: begin send_gap_pct = 15; stall_pct = 0;  end
                default: begin send_gap_pct = 40; stall_pct = 40; end
            endcase
            if (ph == RANDOM_PHASES - 1) begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
                    pause_sender($urandom_range(1, 18));
                else if (ph != RANDOM_PHASES - 1 && $urandom_range(0, 99) == 0)
                    wait_for_replies();
                pick_request(op, tag, len);
                offer(op, tag, len, 0, '0);
                random_sent++;
            end
        end

        // let the last replies drain, then watch for strays
        s_tvalid <= 1'b0;
        for (int t = 0; t < DRAIN_CYCLES && pending_replies.size() != 0; t++)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_replies.size() != 0) begin
            $display("%0d replies never arrived", pending_replies.size());
            fault_count += pending_replies.size();
        end

        $display("covered %0d directed and %0d random requests across %0d block sizes",
                 directed_sent, random_sent, sizes_used);
        $display("replies seen: ok %0d, write-back %0d, miss %0d, full %0d; mismatches %0d",
                 replies_by_status[STAT_OK], replies_by_status[STAT_WB],
                 replies_by_status[STAT_MISS], replies_by_status[STAT_FULL], fault_count);
        if (fault_count == 0)
            $display("lru_write_buffer_directory test passed");
        else
            $display("lru_write_buffer_directory test failed");
        $finish;
    end

    // hard stop if the handshakes ever hang
    initial begin : watchdog
        #(LIMIT_CYCLES * 12);
        $display("lru_write_buffer_directory test failed");
        $finish;
    end

endmodule

[sim.f]
rtl/lruwbd_pkg.sv
rtl/lru_write_buffer_directory.sv
test/lru_write_buffer_directory_tb.sv
